### rtl/crk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Combination rank package
// Transfer types and the constant Pascal table shared by the ranking cells.
// ----------------------------------------------------------------------------
package crk_pkg;

	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 6;
	localparam int TBL_ROWS = 33;
	localparam int IDX_W    = 6;

	typedef struct packed {
		logic [DATA_W-1:0]  combination_mask;
		logic [COUNT_W-1:0] element_count;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] colex_rank;
		logic [DATA_W-1:0] cumulative_index;
	} rsp_t;

	typedef logic [TBL_ROWS-1:0][TBL_ROWS-1:0][DATA_W-1:0] pascal_t;

	function automatic pascal_t build_pascal();
		pascal_t t;
		int      r;
		int      c;
		t = '0;
		for (r = 0; r < TBL_ROWS; r++) begin
			for (c = 0; c <= r; c++) begin
				if (c == 0 || c == r) begin
					t[r][c] = DATA_W'(1);
				end else begin
					t[r][c] = t[r-1][c-1] + t[r-1][c];
				end
			end
		end
		return t;
	endfunction

	localparam pascal_t PASCAL = build_pascal();

endpackage

### rtl/crk_bit_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank bit cell
// Looks at one mask position and, when that bit is set, adds its binomial term to the colex rank.
// ----------------------------------------------------------------------------
module crk_bit_cell
	import crk_pkg::*;
#(
	parameter int MASK_BITS = 32,
	parameter int POS       = 0,
	parameter int KW        = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 valid,
	input  logic [MASK_BITS-1:0] mask,
	input  logic [KW-1:0]        n,
	input  logic [KW-1:0]        k,
	input  logic [DATA_W-1:0]    rank,
	output logic                 valid_q,
	output logic [MASK_BITS-1:0] mask_q,
	output logic [KW-1:0]        n_q,
	output logic [KW-1:0]        k_q,
	output logic [DATA_W-1:0]    rank_q
);

	logic [KW-1:0]     k_inc;
	logic [KW-1:0]     k_nxt;
	logic [DATA_W-1:0] rank_nxt;

	assign k_inc = k + KW'(1);

	always_comb begin
		if (mask[POS]) begin
			k_nxt    = k_inc;
			rank_nxt = rank + PASCAL[POS][IDX_W'(k_inc)];
		end else begin
			k_nxt    = k;
			rank_nxt = rank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mask_q <= mask;
			n_q    <= n;
			k_q    <= k_nxt;
			rank_q <= rank_nxt;
		end
	end

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (k_q <= KW'(POS + 1)))
		else $error("set-bit count exceeds the positions seen");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (valid_q == $past(valid)))
		else $error("cell did not take its neighbor's valid");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!advance && valid_q) |=> (valid_q && $stable(rank_q) && $stable(k_q)))
		else $error("stalled cell changed its contents");

endmodule

### rtl/crk_sum_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cumulative sum cell
// Adds C(n, i) for its own size i when the popcount is above i.
// ----------------------------------------------------------------------------
module crk_sum_cell
	import crk_pkg::*;
#(
	parameter int IDX = 0,
	parameter int KW  = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              valid,
	input  logic [KW-1:0]     n,
	input  logic [KW-1:0]     k,
	input  logic [DATA_W-1:0] rank,
	input  logic [DATA_W-1:0] cum,
	output logic              valid_q,
	output logic [KW-1:0]     n_q,
	output logic [KW-1:0]     k_q,
	output logic [DATA_W-1:0] rank_q,
	output logic [DATA_W-1:0] cum_q
);

	logic [DATA_W-1:0] cum_nxt;

	always_comb begin
		if (k > KW'(IDX)) begin
			cum_nxt = cum + PASCAL[IDX_W'(n)][IDX];
		end else begin
			cum_nxt = cum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			n_q    <= n;
			k_q    <= k;
			rank_q <= rank;
			cum_q  <= cum_nxt;
		end
	end

endmodule

### rtl/combination_cumulative_rank_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Combination cumulative rank unit
// An item passes through the bit cells and then the sum cells, each registered.
// Throughput is one item per cycle; a chain of MASK_BITS bit cells and
// MASK_BITS sum cells advances together, stalling only on the result side.
// Reset clears every cell's valid flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module combination_cumulative_rank_unit
	import crk_pkg::*;
#(
	parameter int MASK_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int KW = $clog2(MASK_BITS + 1);

	logic                 advance;
	logic [KW-1:0]        n_sat;

	logic                 b_valid [0:MASK_BITS];
	logic [MASK_BITS-1:0] b_mask  [0:MASK_BITS];
	logic [KW-1:0]        b_n     [0:MASK_BITS];
	logic [KW-1:0]        b_k     [0:MASK_BITS];
	logic [DATA_W-1:0]    b_rank  [0:MASK_BITS];

	logic                 s_valid [0:MASK_BITS];
	logic [KW-1:0]        s_n     [0:MASK_BITS];
	logic [KW-1:0]        s_k     [0:MASK_BITS];
	logic [DATA_W-1:0]    s_rank  [0:MASK_BITS];
	logic [DATA_W-1:0]    s_cum   [0:MASK_BITS];

	assign advance   = !(rsp_valid && rsp_stall);
	assign req_stall = !advance;

	assign n_sat = (req.element_count > COUNT_W'(MASK_BITS)) ? KW'(MASK_BITS)
	                                                         : KW'(req.element_count);

	assign b_valid[0] = req_valid;
	assign b_mask[0]  = req.combination_mask[MASK_BITS-1:0];
	assign b_n[0]     = n_sat;
	assign b_k[0]     = '0;
	assign b_rank[0]  = '0;

	for (genvar p = 0; p < MASK_BITS; p++) begin : g_bit
		crk_bit_cell #(
			.MASK_BITS(MASK_BITS),
			.POS      (p),
			.KW       (KW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.advance(advance),
			.valid  (b_valid[p]),
			.mask   (b_mask[p]),
			.n      (b_n[p]),
			.k      (b_k[p]),
			.rank   (b_rank[p]),
			.valid_q(b_valid[p+1]),
			.mask_q (b_mask[p+1]),
			.n_q    (b_n[p+1]),
			.k_q    (b_k[p+1]),
			.rank_q (b_rank[p+1])
		);
	end

	assign s_valid[0] = b_valid[MASK_BITS];
	assign s_n[0]     = b_n[MASK_BITS];
	assign s_k[0]     = b_k[MASK_BITS];
	assign s_rank[0]  = b_rank[MASK_BITS];
	assign s_cum[0]   = b_rank[MASK_BITS];

	for (genvar i = 0; i < MASK_BITS; i++) begin : g_sum
		crk_sum_cell #(
			.IDX(i),
			.KW (KW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.advance(advance),
			.valid  (s_valid[i]),
			.n      (s_n[i]),
			.k      (s_k[i]),
			.rank   (s_rank[i]),
			.cum    (s_cum[i]),
			.valid_q(s_valid[i+1]),
			.n_q    (s_n[i+1]),
			.k_q    (s_k[i+1]),
			.rank_q (s_rank[i+1]),
			.cum_q  (s_cum[i+1])
		);
	end

	assign rsp_valid            = s_valid[MASK_BITS];
	assign rsp.colex_rank       = s_rank[MASK_BITS];
	assign rsp.cumulative_index = s_cum[MASK_BITS];

endmodule
